// File: hdl/fhm_pkg.sv
// ----------------------------------------------------------------------------
// fhm_pkg
// shared types and codes for the mutex with first-come wait queue
// ----------------------------------------------------------------------------
package fhm_pkg;

	localparam int TASK_W        = 4;
	localparam int OP_W          = 2;
	localparam int STATUS_W      = 3;
	localparam int MAX_TASKS_DEF = 16;

	localparam logic [OP_W-1:0] OP_LOCK   = 2'd0;
	localparam logic [OP_W-1:0] OP_UNLOCK = 2'd1;
	localparam logic [OP_W-1:0] OP_TRY    = 2'd2;

	localparam logic [STATUS_W-1:0] ST_ACQUIRED   = 3'd0;
	localparam logic [STATUS_W-1:0] ST_QUEUED     = 3'd1;
	localparam logic [STATUS_W-1:0] ST_TRY_FAILED = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NOT_OWNER  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FREED      = 3'd4;
	localparam logic [STATUS_W-1:0] ST_HANDED     = 3'd5;
	localparam logic [STATUS_W-1:0] ST_QUEUE_FULL = 3'd6;

	typedef struct packed {
		logic [OP_W-1:0]   operation;
		logic [TASK_W-1:0] task_id;
	} req_word_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                woken_valid;
		logic [TASK_W-1:0]   woken_task;
		logic [TASK_W-1:0]   owner_now;
		logic                held_now;
	} rsp_word_t;

endpackage

// File: hdl/fhm_ring.sv
// ----------------------------------------------------------------------------
// fhm_ring
// waiter ring storage, one write port and one registered read port
// ----------------------------------------------------------------------------
module fhm_ring #(
	parameter int DEPTH = fhm_pkg::MAX_TASKS_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [AW-1:0]             wr_addr,
	input  logic [fhm_pkg::TASK_W-1:0] wr_data,
	input  logic                      rd_en,
	input  logic [AW-1:0]             rd_addr,
	output logic [fhm_pkg::TASK_W-1:0] rd_data
);

	logic [fhm_pkg::TASK_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: hdl/fifo_handoff_mutex_unit.sv
// ----------------------------------------------------------------------------
// fifo_handoff_mutex_unit
// hardware mutex with a first-come wait queue and direct handover on unlock
// ----------------------------------------------------------------------------
// When a request is accepted, the head entry of the waiter ring memory is read.
// In the decide stage that follows, the request is decided, the ring tail entry
// is written and the response word is loaded into the output register. A new
// request is accepted only once the decide stage is empty, also while an earlier
// response still waits in the output register; a request stays in the decide
// stage only while that register is full and stalled. The ring needs no clearing
// after reset: only entries written since are read.
// ----------------------------------------------------------------------------
module fifo_handoff_mutex_unit #(
	parameter int MAX_TASKS = fhm_pkg::MAX_TASKS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  fhm_pkg::req_word_t req,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output fhm_pkg::rsp_word_t rsp
);

	localparam int PW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int CW = $clog2(MAX_TASKS + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(MAX_TASKS - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(MAX_TASKS);

	logic                       held_q;
	logic [fhm_pkg::TASK_W-1:0] owner_q;
	logic [PW-1:0]              head_q;
	logic [PW-1:0]              tail_q;
	logic [CW-1:0]              count_q;

	logic                       valid_s1;
	fhm_pkg::req_word_t         req_s1;
	logic [fhm_pkg::TASK_W-1:0] head_data_s1;

	logic                       req_take;
	logic                       s1_done;

	logic                       held_d;
	logic [fhm_pkg::TASK_W-1:0] owner_d;
	logic                       push;
	logic                       pop;
	fhm_pkg::rsp_word_t         rsp_d;

	assign req_stall = valid_s1;
	assign req_take  = req_valid && !req_stall;
	assign s1_done   = valid_s1 && (!rsp_valid || !rsp_stall);

	// head entry read, decide stage is empty so no write overlaps it
	fhm_ring #(
		.DEPTH (MAX_TASKS),
		.AW    (PW)
	) u_ring (
		.clk     (clk),
		.wr_en   (s1_done && push),
		.wr_addr (tail_q),
		.wr_data (req_s1.task_id),
		.rd_en   (req_take),
		.rd_addr (head_q),
		.rd_data (head_data_s1)
	);

	always_comb begin
		held_d            = held_q;
		owner_d           = owner_q;
		push              = 1'b0;
		pop               = 1'b0;
		rsp_d.status      = fhm_pkg::ST_NOT_OWNER;
		rsp_d.woken_valid = 1'b0;
		rsp_d.woken_task  = '0;
		case (req_s1.operation)
			fhm_pkg::OP_LOCK: begin
				if (!held_q) begin
					held_d       = 1'b1;
					owner_d      = req_s1.task_id;
					rsp_d.status = fhm_pkg::ST_ACQUIRED;
				end else if (count_q == CNT_FULL) begin
					rsp_d.status = fhm_pkg::ST_QUEUE_FULL;
				end else begin
					push         = 1'b1;
					rsp_d.status = fhm_pkg::ST_QUEUED;
				end
			end
			fhm_pkg::OP_UNLOCK: begin
				if (!held_q || owner_q != req_s1.task_id) begin
					rsp_d.status = fhm_pkg::ST_NOT_OWNER;
				end else if (count_q != '0) begin
					pop               = 1'b1;
					owner_d           = head_data_s1;
					rsp_d.status      = fhm_pkg::ST_HANDED;
					rsp_d.woken_valid = 1'b1;
					rsp_d.woken_task  = head_data_s1;
				end else begin
					held_d       = 1'b0;
					owner_d      = '0;
					rsp_d.status = fhm_pkg::ST_FREED;
				end
			end
			default: begin
				// trylock, both codes with the upper bit set
				if (!held_q) begin
					held_d       = 1'b1;
					owner_d      = req_s1.task_id;
					rsp_d.status = fhm_pkg::ST_ACQUIRED;
				end else begin
					rsp_d.status = fhm_pkg::ST_TRY_FAILED;
				end
			end
		endcase
		rsp_d.owner_now = owner_d;
		rsp_d.held_now  = held_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_take) begin
			valid_s1 <= 1'b1;
		end else if (s1_done) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_take) begin
			req_s1 <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q  <= 1'b0;
			owner_q <= '0;
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else if (s1_done) begin
			held_q  <= held_d;
			owner_q <= owner_d;
			if (push) begin
				tail_q  <= (tail_q == PTR_LAST) ? '0 : tail_q + PW'(1);
				count_q <= count_q + CW'(1);
			end
			if (pop) begin
				head_q  <= (head_q == PTR_LAST) ? '0 : head_q + PW'(1);
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (s1_done) begin
			rsp_valid <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_done) begin
			rsp <= rsp_d;
		end
	end

endmodule

// File: tb/tb_fifo_handoff_mutex_unit.sv
// ----------------------------------------------------------------------------
// tb_fifo_handoff_mutex_unit
// self-checking testbench for the mutex with first-come wait queue
// ----------------------------------------------------------------------------
// A scoreboard class keeps its own copy of the owner, the held flag and the
// waiter ring. It works out the expected response word for every accepted
// request and checks each accepted response word against the oldest one.
// A short directed part covers the unusual cases. Random phases follow:
// mixed traffic, fill-and-drain runs that hit a full queue and then hand
// over to every waiter, and pure noise. Both sides idle and stall at random.
// ----------------------------------------------------------------------------

class mutex_scoreboard;

	bit                              held;
	logic [fhm_pkg::TASK_W-1:0]      owner;
	logic [fhm_pkg::TASK_W-1:0]      waiters [fhm_pkg::MAX_TASKS_DEF];
	int                              rd_ptr;
	int                              wr_ptr;
	int                              depth;
	int                              mismatches;
	fhm_pkg::rsp_word_t              pending_rsp [$];

	function new();
		held       = 1'b0;
		owner      = '0;
		rd_ptr     = 0;
		wr_ptr     = 0;
		depth      = 0;
		mismatches = 0;
	endfunction

	function int pending();
		return pending_rsp.size();
	endfunction

	function void note_request(fhm_pkg::req_word_t w);
		fhm_pkg::rsp_word_t e;
		e = '0;
		if (w.operation[1]) begin
			if (!held) begin
				held     = 1'b1;
				owner    = w.task_id;
				e.status = fhm_pkg::ST_ACQUIRED;
			end else begin
				e.status = fhm_pkg::ST_TRY_FAILED;
			end
		end else if (w.operation == fhm_pkg::OP_LOCK) begin
			if (!held) begin
				held     = 1'b1;
				owner    = w.task_id;
				e.status = fhm_pkg::ST_ACQUIRED;
			end else if (depth >= fhm_pkg::MAX_TASKS_DEF) begin
				e.status = fhm_pkg::ST_QUEUE_FULL;
			end else begin
				waiters[wr_ptr] = w.task_id;
				wr_ptr   = (wr_ptr + 1) % fhm_pkg::MAX_TASKS_DEF;
				depth++;
				e.status = fhm_pkg::ST_QUEUED;
			end
		end else begin
			if (!held || owner != w.task_id) begin
				e.status = fhm_pkg::ST_NOT_OWNER;
			end else if (depth > 0) begin
				owner        = waiters[rd_ptr];
				rd_ptr       = (rd_ptr + 1) % fhm_pkg::MAX_TASKS_DEF;
				depth--;
				e.woken_valid = 1'b1;
				e.woken_task  = owner;
				e.status      = fhm_pkg::ST_HANDED;
			end else begin
				held     = 1'b0;
				owner    = '0;
				e.status = fhm_pkg::ST_FREED;
			end
		end
		e.held_now  = held;
		e.owner_now = held ? owner : '0;
		pending_rsp.push_back(e);
	endfunction

	function void compare_field(string name, int exp_val, int got_val);
		if (exp_val != got_val) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name,
				exp_val, got_val);
		end
	endfunction

	function void check_rsp(fhm_pkg::rsp_word_t got);
		fhm_pkg::rsp_word_t e;
		if (pending_rsp.size() == 0) begin
			mismatches++;
			$display("%0t: unexpected response word, expected none, actual %h", $time, got);
			return;
		end
		e = pending_rsp.pop_front();
		compare_field("status", int'(e.status), int'(got.status));
		compare_field("woken_valid", int'(e.woken_valid), int'(got.woken_valid));
		compare_field("woken_task", int'(e.woken_task), int'(got.woken_task));
		compare_field("owner_now", int'(e.owner_now), int'(got.owner_now));
		compare_field("held_now", int'(e.held_now), int'(got.held_now));
	endfunction

endclass

module tb_fifo_handoff_mutex_unit;

	import fhm_pkg::*;

	localparam logic [OP_W-1:0] OP_TRY_ALIAS = OP_TRY | OP_UNLOCK;
	localparam int              ITEM_TARGET  = 400;
	localparam int              CYCLE_LIMIT  = 200000;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      req_valid;
	logic      req_stall;
	req_word_t req;
	logic      rsp_valid;
	logic      rsp_stall;
	rsp_word_t rsp;

	mutex_scoreboard board;
	bit              no_idle;
	int              words_sent;
	int              cycle_count = 0;

	fifo_handoff_mutex_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("** fifo_handoff_mutex_unit: FAILED **");
			$finish;
		end
	end

	task automatic send_word(input logic [OP_W-1:0] op, input logic [TASK_W-1:0] id);
		int        gap;
		req_word_t w;
		w.operation = op;
		w.task_id   = id;
		gap = no_idle ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= w;
		do @(posedge clk); while (req_stall);
		board.note_request(w);
		words_sent++;
	endtask

	task automatic drain_all();
		req_valid <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0) @(posedge clk);
	endtask

	task automatic send_try(input logic [TASK_W-1:0] id);
		send_word($urandom_range(0, 1) ? OP_TRY : OP_TRY_ALIAS, id);
	endtask

	task automatic mixed_phase(input int count);
		int r;
		repeat (count) begin
			r = $urandom_range(0, 99);
			if (r < 40)
				send_word(OP_LOCK, 4'($urandom_range(0, 15)));
			else if (r < 75) begin
				if (board.held && $urandom_range(0, 9) < 7)
					send_word(OP_UNLOCK, board.owner);
				else
					send_word(OP_UNLOCK, 4'($urandom_range(0, 15)));
			end else
				send_try(4'($urandom_range(0, 15)));
		end
	endtask

	task automatic fill_drain_phase();
		while (board.depth < MAX_TASKS_DEF)
			send_word(OP_LOCK, 4'($urandom_range(0, 15)));
		repeat ($urandom_range(1, 2)) send_word(OP_LOCK, 4'($urandom_range(0, 15)));
		while (board.held) begin
			if ($urandom_range(0, 9) < 2) begin
				if ($urandom_range(0, 1))
					send_word(OP_UNLOCK, board.owner + 4'($urandom_range(1, 15)));
				else
					send_try(4'($urandom_range(0, 15)));
			end else
				send_word(OP_UNLOCK, board.owner);
		end
	endtask

	task automatic noise_phase(input int count);
		repeat (count) send_word(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)));
	endtask

	initial begin
		rsp_stall <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			int n;
			n = no_idle ? 0 : $urandom_range(0, 6);
			if (n > 0) begin
				rsp_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			do @(posedge clk); while (!rsp_valid);
			board.check_rsp(rsp);
		end
	end

	initial begin
		int kind;
		board       = new();
		no_idle     = 1'b0;
		words_sent  = 0;
		arst_n    <= 1'b0;
		req_valid <= 1'b0;
		req       <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part
		send_word(OP_UNLOCK, 4'd0);
		send_word(OP_LOCK, 4'd3);
		send_word(OP_UNLOCK, 4'd5);
		send_word(OP_TRY, 4'd7);
		send_word(OP_TRY_ALIAS, 4'd9);
		send_word(OP_LOCK, 4'd3);
		send_word(OP_LOCK, 4'd15);
		send_word(OP_LOCK, 4'd0);
		send_word(OP_UNLOCK, 4'd3);
		send_word(OP_UNLOCK, 4'd3);
		send_word(OP_UNLOCK, 4'd15);
		send_word(OP_UNLOCK, 4'd0);
		send_word(OP_TRY_ALIAS, 4'd15);
		send_word(OP_UNLOCK, 4'd15);
		send_word(OP_TRY, 4'd0);
		send_word(OP_UNLOCK, 4'd0);
		drain_all();

		fill_drain_phase();
		while (words_sent < ITEM_TARGET) begin
			no_idle = ($urandom_range(0, 4) == 0);
			kind    = $urandom_range(0, 9);
			if (kind < 5)
				mixed_phase($urandom_range(10, 30));
			else if (kind < 8)
				fill_drain_phase();
			else
				noise_phase($urandom_range(5, 15));
			if ($urandom_range(0, 3) == 0)
				drain_all();
		end
		no_idle = 1'b0;

		drain_all();
		repeat (10) @(posedge clk);
		if (board.mismatches == 0 && board.pending() == 0)
			$display("** fifo_handoff_mutex_unit: PASSED **");
		else
			$display("** fifo_handoff_mutex_unit: FAILED **");
		$finish;
	end

endmodule
